// ===== rtl/grammar_token_scanner_defines.svh =====
// assertion macros for the grammar token scanner checker
// no dependencies; included by the checker file
`ifndef GRAMMAR_TOKEN_SCANNER_DEFINES_SVH
`define GRAMMAR_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grammar token scanner check failed");

// next-cycle implication, sampled on clk, off during reset
`define GTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grammar token scanner check failed");

`endif

// ===== rtl/gts_pkg.sv =====
// shared types and constants for the grammar token scanner
// no dependencies; imported by every module of the block
`default_nettype none

package gts_pkg;

	// token kind codes
	localparam logic [4:0] K_WS      = 5'd0;
	localparam logic [4:0] K_COMMENT = 5'd1;
	localparam logic [4:0] K_ERROR   = 5'd2;
	localparam logic [4:0] K_AT      = 5'd3;
	localparam logic [4:0] K_COLON   = 5'd4;
	localparam logic [4:0] K_SEMI    = 5'd5;
	localparam logic [4:0] K_COMMA   = 5'd6;
	localparam logic [4:0] K_LPAREN  = 5'd7;
	localparam logic [4:0] K_RPAREN  = 5'd8;
	localparam logic [4:0] K_LBRACE  = 5'd9;
	localparam logic [4:0] K_RBRACE  = 5'd10;
	localparam logic [4:0] K_QMARK   = 5'd11;
	localparam logic [4:0] K_STAR    = 5'd12;
	localparam logic [4:0] K_PLUS    = 5'd13;
	localparam logic [4:0] K_BAR     = 5'd14;
	localparam logic [4:0] K_INT     = 5'd15;
	localparam logic [4:0] K_LSEQ    = 5'd16;
	localparam logic [4:0] K_LALT    = 5'd17;
	localparam logic [4:0] K_IDENT   = 5'd18;
	localparam logic [4:0] K_NONE    = 5'd0;

	// result queue depth and pointer width
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = 2;

	// scanner run state
	typedef enum logic [6:0] {
		M_IDLE    = 7'b0000001,
		M_BLANK   = 7'b0000010,
		M_INT     = 7'b0000100,
		M_IDENT   = 7'b0001000,
		M_COMMENT = 7'b0010000,
		M_LSEQ    = 7'b0100000,
		M_LALT    = 7'b1000000
	} mode_t;

	// one result beat
	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] offs;
		logic        last;
	} token_t;

	// up to two results produced by one source byte
	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} push_t;

endpackage

`default_nettype wire

// ===== rtl/grammar_token_scanner.sv =====
// grammar token scanner: one source byte per beat in, one token per beat out
// the input register holds each byte while the scan core decodes it into the result queue
// throughput: one byte per cycle while bytes yield at most one token each and the output
// is not stalled; one token leaves per beat, so bytes closing two tokens can stall the input
// reset: arst_n clears the scan state, the offset counter and the result queue
// depends on gts_pkg, gts_scan_core, gts_out_fifo
`default_nettype none

module grammar_token_scanner
	import gts_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  source_byte,
	input  wire logic        end_of_source,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       kind_code,
	output logic [31:0]      end_offset,
	output logic             last_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room;
	logic       go;
	logic       accept;
	push_t      push;
	token_t     head;

	assign go       = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= source_byte;
			last_s1 <= end_of_source;
		end
	end

	// scan logic
	gts_scan_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.push    (push)
	);

	// result queue
	gts_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind_code   = head.kind;
	assign end_offset  = head.offs;
	assign last_of_run = head.last;

endmodule

`default_nettype wire

// ===== rtl/gts_scan_core.sv =====
// per-byte scan logic and scanner state registers
// depends on gts_pkg
`default_nettype none

module gts_scan_core
	import gts_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [7:0] byte_s1,
	input  wire logic       last_s1,
	output push_t           push
);

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [OFFSET_BITS-1:0] POS_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	localparam logic [OFFSET_BITS-1:0] POS_ZERO = '0;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_ident_begin(input logic [7:0] c);
		return (c == CH_UNDER) || ((c >= 8'h61) && (c <= 8'h7A)) ||
			((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			8'h40: k = K_AT;
			8'h3A: k = K_COLON;
			8'h3B: k = K_SEMI;
			8'h2C: k = K_COMMA;
			8'h28: k = K_LPAREN;
			8'h29: k = K_RPAREN;
			8'h7B: k = K_LBRACE;
			8'h7D: k = K_RBRACE;
			8'h3F: k = K_QMARK;
			8'h2A: k = K_STAR;
			8'h2B: k = K_PLUS;
			8'h7C: k = K_BAR;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] run_kind(input mode_t m);
		logic [4:0] k;
		case (m)
			M_BLANK: k = K_WS;
			M_INT:   k = K_INT;
			M_IDENT: k = K_IDENT;
			default: k = K_COMMENT;
		endcase
		return k;
	endfunction

	// append one token into the first free slot
	function automatic push_t add_tok(input push_t p, input logic [4:0] k,
			input logic [31:0] o);
		push_t r;
		r = p;
		if (p.cnt == 2'd0) begin
			r.tok0.kind = k;
			r.tok0.offs = o;
			r.cnt = 2'd1;
		end else if (p.cnt == 2'd1) begin
			r.tok1.kind = k;
			r.tok1.offs = o;
			r.cnt = 2'd2;
		end
		return r;
	endfunction

	mode_t                  mode_q, mode_n;
	logic                   esc_q, esc_n;
	logic                   err_q, err_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [OFFSET_BITS-1:0] lit_q, lit_n;

	logic [OFFSET_BITS-1:0] nxt;
	logic [31:0]            pos32, nxt32, lit32;
	logic                   consumed;
	logic                   cont;
	logic [4:0]             pk;
	push_t                  p;

	assign nxt   = pos_q + POS_ONE;
	assign pos32 = 32'(pos_q);
	assign nxt32 = 32'(nxt);
	assign lit32 = 32'(lit_q);
	assign pk    = punct_kind(byte_s1);

	// next state and emitted tokens for the byte in the input register
	always_comb begin
		mode_n   = mode_q;
		esc_n    = esc_q;
		err_n    = err_q;
		lit_n    = lit_q;
		pos_n    = nxt;
		consumed = 1'b0;
		cont     = 1'b0;
		p        = '0;

		// continue or close the open token
		case (mode_q)
			M_BLANK, M_INT, M_IDENT: begin
				if (mode_q == M_BLANK)
					cont = is_blank(byte_s1);
				else if (mode_q == M_INT)
					cont = is_digit(byte_s1);
				else
					cont = is_ident_begin(byte_s1) || is_digit(byte_s1);
				if (cont) begin
					consumed = 1'b1;
				end else begin
					p = add_tok(p, run_kind(mode_q), pos32);
					mode_n = M_IDLE;
				end
			end
			M_COMMENT: begin
				consumed = 1'b1;
				if (byte_s1 == CH_NL) begin
					p = add_tok(p, K_COMMENT, nxt32);
					mode_n = M_IDLE;
				end
			end
			M_LSEQ, M_LALT: begin
				consumed = 1'b1;
				if (esc_q) begin
					esc_n = 1'b0;
				end else if (byte_s1 == ((mode_q == M_LSEQ) ? CH_QUOTE : CH_RBRK)) begin
					if (err_n)
						p = add_tok(p, K_ERROR, lit32);
					err_n = 1'b0;
					p = add_tok(p, (mode_q == M_LSEQ) ? K_LSEQ : K_LALT, nxt32);
					mode_n = M_IDLE;
				end else if (byte_s1 == CH_BSL) begin
					esc_n = 1'b1;
				end
			end
			default: begin
				mode_n = M_IDLE;
			end
		endcase

		// start a new token with this byte
		if (!consumed) begin
			if (is_blank(byte_s1)) begin
				if (err_n)
					p = add_tok(p, K_ERROR, pos32);
				err_n = 1'b0;
				mode_n = M_BLANK;
			end else if (byte_s1 == CH_NL) begin
				if (err_n)
					p = add_tok(p, K_ERROR, pos32);
				err_n = 1'b0;
				p = add_tok(p, K_WS, nxt32);
			end else if (byte_s1 == CH_HASH) begin
				if (err_n)
					p = add_tok(p, K_ERROR, pos32);
				err_n = 1'b0;
				mode_n = M_COMMENT;
			end else if (pk != K_NONE) begin
				if (err_n)
					p = add_tok(p, K_ERROR, pos32);
				err_n = 1'b0;
				p = add_tok(p, pk, nxt32);
			end else if ((byte_s1 == CH_QUOTE) || (byte_s1 == CH_LBRK)) begin
				mode_n = (byte_s1 == CH_QUOTE) ? M_LSEQ : M_LALT;
				lit_n = pos_q;
				esc_n = 1'b0;
			end else if (is_digit(byte_s1)) begin
				if (err_n)
					p = add_tok(p, K_ERROR, pos32);
				err_n = 1'b0;
				mode_n = M_INT;
			end else if (is_ident_begin(byte_s1)) begin
				if (err_n)
					p = add_tok(p, K_ERROR, pos32);
				err_n = 1'b0;
				mode_n = M_IDENT;
			end else begin
				err_n = 1'b1;
			end
		end

		// end of source flushes everything and restarts at offset zero
		if (last_s1) begin
			if ((mode_n == M_BLANK) || (mode_n == M_INT) || (mode_n == M_IDENT) ||
					(mode_n == M_COMMENT))
				p = add_tok(p, run_kind(mode_n), nxt32);
			else if ((mode_n == M_LSEQ) || (mode_n == M_LALT))
				err_n = 1'b1;
			if (err_n)
				p = add_tok(p, K_ERROR, nxt32);
			mode_n = M_IDLE;
			esc_n  = 1'b0;
			err_n  = 1'b0;
			pos_n  = POS_ZERO;
			lit_n  = POS_ZERO;
		end

		// mark the final token of this byte
		if (p.cnt == 2'd1)
			p.tok0.last = 1'b1;
		else if (p.cnt == 2'd2)
			p.tok1.last = 1'b1;
	end

	assign push = go ? p : '0;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			esc_q  <= 1'b0;
			err_q  <= 1'b0;
			pos_q  <= POS_ZERO;
			lit_q  <= POS_ZERO;
		end else if (go) begin
			mode_q <= mode_n;
			esc_q  <= esc_n;
			err_q  <= err_n;
			pos_q  <= pos_n;
			lit_q  <= lit_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gts_out_fifo.sv =====
// result queue: takes up to two tokens per cycle, hands out one per beat
// depends on gts_pkg
`default_nettype none

module gts_out_fifo
	import gts_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_stall,
	output token_t     head
);

	token_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 pop;
	logic [FIFO_AW-1:0]   wr_ptr_p1;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = mem[rd_ptr_q];
	assign room      = (count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	// token storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem[wr_ptr_q] <= push.tok0;
		if (push.cnt == 2'd2)
			mem[wr_ptr_p1] <= push.tok1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.cnt);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			count_q  <= count_q + (FIFO_AW + 1)'(push.cnt) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gts_checker.sv =====
// port-level checks for the grammar token scanner, bound to the top level
// depends on gts_pkg and grammar_token_scanner_defines.svh
`default_nettype none

`include "grammar_token_scanner_defines.svh"

module gts_checker
	import gts_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [4:0]  kind_code,
	input wire logic [31:0] end_offset,
	input wire logic        last_of_run
);

	// only defined kind codes leave the block
	`GTS_ASSERT_NOW(a_kind_range, out_valid, kind_code <= K_IDENT)

	// a stalled beat holds its payload
	`GTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(kind_code) && $stable(end_offset) && $stable(last_of_run))

	// the second token of a byte is already queued behind the first
	`GTS_ASSERT_NEXT(a_pair_follows, out_valid && !out_stall && !last_of_run, out_valid)

	// an error token is never the first of a pair followed by another error
	`GTS_ASSERT_NEXT(a_no_double_error,
		out_valid && !out_stall && !last_of_run && (kind_code == K_ERROR),
		kind_code != K_ERROR)

	// input back-pressure only while results are waiting
	`GTS_ASSERT_NOW(a_stall_has_backlog, in_stall, out_valid)

endmodule

bind grammar_token_scanner gts_checker u_gts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kind_code   (kind_code),
	.end_offset  (end_offset),
	.last_of_run (last_of_run)
);

`default_nettype wire

// ===== verif/grammar_token_scanner_tb.sv =====
// self-checking testbench for the grammar token scanner: byte stream in, token beats out
// depends on gts_pkg and grammar_token_scanner; carries its own token predictor
`default_nettype none

module grammar_token_scanner_tb;
	import gts_pkg::*;

	// character codes the scanner reacts to
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_RBRK  = 8'h5d;

	localparam string IDENT_CHARS = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
	localparam string PUNCT_CHARS = "@:;,(){}?*+|";
	localparam int    SOURCE_ITEMS = 1650;
	localparam int    HOLD_OFF_CYCLES = 300;

	typedef struct {
		logic [7:0]  data;
		logic        eos;
		int unsigned idle;
	} byte_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  source_byte = 8'h00;
	logic        end_of_source = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  kind_code;
	logic [31:0] end_offset;
	logic        last_of_run;

	byte_beat_t  pending_bytes[$];
	token_t      expected_tokens[$];
	int unsigned accepted_bytes = 0;
	int unsigned fault_count = 0;
	int unsigned tx_calm_left = 0;
	int unsigned rx_calm_left = 0;
	int unsigned rx_stall_left = 0;
	int unsigned pushed_bytes = 0;
	logic        hold_off = 1'b0;

	// predictor state
	mode_t       scan_state = M_IDLE;
	logic        esc_wait = 1'b0;
	logic        err_pending = 1'b0;
	logic [31:0] next_offs = '0;
	logic [31:0] lit_open_at = '0;
	int          step_tokens;

	grammar_token_scanner i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.source_byte   (source_byte),
		.end_of_source (end_of_source),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind_code     (kind_code),
		.end_offset    (end_offset),
		.last_of_run   (last_of_run)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// character classes
	function automatic logic digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic ident_lead(input logic [7:0] c);
		return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic ident_char(input logic [7:0] c);
		return ident_lead(c) || digit_char(c);
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR;
	endfunction

	function automatic logic [4:0] punct_code(input logic [7:0] c);
		case (c)
			"@": return K_AT;
			":": return K_COLON;
			";": return K_SEMI;
			",": return K_COMMA;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			"?": return K_QMARK;
			"*": return K_STAR;
			"+": return K_PLUS;
			"|": return K_BAR;
			default: return K_NONE;
		endcase
	endfunction

	function automatic logic [4:0] run_code(input mode_t m);
		case (m)
			M_BLANK: return K_WS;
			M_INT:   return K_INT;
			M_IDENT: return K_IDENT;
			default: return K_COMMENT;
		endcase
	endfunction

	// queue one expected token, at most two per byte
	function automatic void note_token(input logic [4:0] kind, input logic [31:0] offs);
		token_t t;
		if (step_tokens < 2) begin
			t.kind = kind;
			t.offs = offs;
			t.last = 1'b0;
			expected_tokens.push_back(t);
			step_tokens++;
		end
	endfunction

	function automatic void flush_error(input logic [31:0] offs);
		if (err_pending) begin
			note_token(K_ERROR, offs);
			err_pending = 1'b0;
		end
	endfunction

	// advance the scanner by one accepted byte and queue the tokens it closes
	task automatic scan_byte(input logic [7:0] c, input logic eos);
		logic [31:0] here;
		logic [31:0] after;
		logic        took;
		logic        cont;
		logic [4:0]  pk;
		logic [7:0]  closer;
		here = next_offs;
		after = next_offs + 32'd1;
		took = 1'b0;
		step_tokens = 0;

		// continue or close the open token
		case (scan_state)
			M_BLANK, M_INT, M_IDENT: begin
				cont = (scan_state == M_BLANK) ? blank_char(c) :
					(scan_state == M_INT) ? digit_char(c) : ident_char(c);
				if (cont) begin
					took = 1'b1;
				end else begin
					note_token(run_code(scan_state), here);
					scan_state = M_IDLE;
				end
			end
			M_COMMENT: begin
				took = 1'b1;
				if (c == CH_LF) begin
					note_token(K_COMMENT, after);
					scan_state = M_IDLE;
				end
			end
			M_LSEQ, M_LALT: begin
				closer = (scan_state == M_LSEQ) ? CH_QUOTE : CH_RBRK;
				took = 1'b1;
				if (esc_wait) begin
					esc_wait = 1'b0;
				end else if (c == closer) begin
					flush_error(lit_open_at);
					note_token((scan_state == M_LSEQ) ? K_LSEQ : K_LALT, after);
					scan_state = M_IDLE;
				end else if (c == CH_BSL) begin
					esc_wait = 1'b1;
				end
			end
			default: scan_state = M_IDLE;
		endcase

		// start a new token
		if (!took) begin
			pk = punct_code(c);
			if (blank_char(c)) begin
				flush_error(here);
				scan_state = M_BLANK;
			end else if (c == CH_LF) begin
				flush_error(here);
				note_token(K_WS, after);
			end else if (c == CH_HASH) begin
				flush_error(here);
				scan_state = M_COMMENT;
			end else if (pk != K_NONE) begin
				flush_error(here);
				note_token(pk, after);
			end else if (c == CH_QUOTE || c == CH_LBRK) begin
				scan_state = (c == CH_QUOTE) ? M_LSEQ : M_LALT;
				lit_open_at = here;
				esc_wait = 1'b0;
			end else if (digit_char(c)) begin
				flush_error(here);
				scan_state = M_INT;
			end else if (ident_lead(c)) begin
				flush_error(here);
				scan_state = M_IDENT;
			end else begin
				err_pending = 1'b1;
			end
		end

		// end of source flushes everything and restarts at offset zero
		if (eos) begin
			if (scan_state == M_BLANK || scan_state == M_INT || scan_state == M_IDENT ||
				scan_state == M_COMMENT)
				note_token(run_code(scan_state), after);
			else if (scan_state == M_LSEQ || scan_state == M_LALT)
				err_pending = 1'b1;
			flush_error(after);
			scan_state = M_IDLE;
			esc_wait = 1'b0;
			err_pending = 1'b0;
			next_offs = '0;
			lit_open_at = '0;
		end else begin
			next_offs = after;
		end

		if (step_tokens > 0)
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endtask

	// stimulus building
	task automatic push_byte(input logic [7:0] c);
		byte_beat_t b;
		b.data = c;
		b.eos = 1'b0;
		if (tx_calm_left != 0) begin
			b.idle = 0;
			tx_calm_left--;
		end else begin
			b.idle = pick_gap();
			if ($urandom_range(0, 49) == 0)
				tx_calm_left = $urandom_range(30, 150);
		end
		pending_bytes.push_back(b);
		pushed_bytes++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic end_source();
		pending_bytes[pending_bytes.size() - 1].eos = 1'b1;
	endtask

	// literal content with random bytes; delimiters and backslashes get escaped
	task automatic push_lit_body(input logic [7:0] closer, input int n);
		logic [7:0] b;
		for (int k = 0; k < n; k++) begin
			b = 8'($urandom_range(0, 255));
			if (b == closer || b == CH_BSL || $urandom_range(0, 9) == 0)
				push_byte(CH_BSL);
			push_byte(b);
		end
	endtask

	// one source of mostly well-formed tokens, some noise and broken literals
	task automatic push_source();
		int         n;
		int         r;
		logic [7:0] b;
		n = $urandom_range(1, 24);
		for (int t = 0; t < n; t++) begin
			r = $urandom_range(0, 99);
			if (r < 14) begin
				push_byte(IDENT_CHARS[$urandom_range(0, 52)]);
				repeat ($urandom_range(0, 6))
					push_byte(IDENT_CHARS[$urandom_range(0, IDENT_CHARS.len() - 1)]);
			end else if (r < 24) begin
				repeat ($urandom_range(1, 5))
					push_byte(8'("0" + $urandom_range(0, 9)));
			end else if (r < 36) begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 2))
						0: push_byte(CH_SP);
						1: push_byte(CH_TAB);
						default: push_byte(CH_CR);
					endcase
				end
			end else if (r < 44) begin
				push_byte(CH_LF);
			end else if (r < 50) begin
				push_byte(CH_HASH);
				repeat ($urandom_range(0, 6)) begin
					b = 8'($urandom_range(0, 255));
					push_byte((b == CH_LF) ? CH_SP : b);
				end
				if ($urandom_range(0, 4) != 0)
					push_byte(CH_LF);
			end else if (r < 70) begin
				push_byte(PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)]);
			end else if (r < 78) begin
				push_byte(CH_QUOTE);
				push_lit_body(CH_QUOTE, $urandom_range(0, 6));
				push_byte(CH_QUOTE);
			end else if (r < 84) begin
				push_byte(CH_LBRK);
				push_lit_body(CH_RBRK, $urandom_range(0, 6));
				push_byte(CH_RBRK);
			end else if (r < 93) begin
				repeat ($urandom_range(1, 3))
					push_byte(8'($urandom_range(0, 255)));
			end else begin
				// literal left open: closes later or turns into an error at the end
				push_byte(($urandom_range(0, 1) != 0) ? CH_QUOTE : CH_LBRK);
				push_lit_body(CH_RBRK, $urandom_range(0, 3));
			end
		end
		end_source();
	endtask

	// driver: offers the queued bytes, holds the beat while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				scan_byte(source_byte, end_of_source);
				accepted_bytes++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_bytes[0].idle != 0) begin
					pending_bytes[0].idle = pending_bytes[0].idle - 1;
					in_valid <= 1'b0;
				end else begin
					source_byte <= pending_bytes[0].data;
					end_of_source <= pending_bytes[0].eos;
					in_valid <= 1'b1;
					void'(pending_bytes.pop_front());
				end
			end
		end
	end

	// monitor: checks each token beat against the oldest expected token
	always @(posedge clk) begin
		token_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tokens.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected token: kind %0d end %0d last %0b",
						kind_code, end_offset, last_of_run);
			end else begin
				want = expected_tokens.pop_front();
				if (want.kind !== kind_code || want.offs !== end_offset ||
					want.last !== last_of_run) begin
					fault_count++;
					if (fault_count <= 10)
						$display("token mismatch: kind %0d/%0d end %0d/%0d last %0b/%0b",
							want.kind, kind_code, want.offs, end_offset,
							want.last, last_of_run);
				end
			end
		end

		// receiver stall pattern
		if (hold_off) begin
			out_stall <= 1'b1;
		end else if (rx_stall_left != 0) begin
			out_stall <= 1'b1;
			rx_stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (rx_calm_left != 0) begin
				rx_calm_left--;
			end else begin
				rx_stall_left = pick_gap();
				if ($urandom_range(0, 49) == 0)
					rx_calm_left = $urandom_range(30, 150);
			end
		end
	end

	// long receiver hold-off so the block fills up and stalls its input
	initial begin
		while (accepted_bytes < 400)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES)
			@(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	// reset, stimulus and end of run
	initial begin
		// directed: error merge before punctuation, all punctuation kinds
		push_byte(8'h00);
		push_byte(8'hff);
		push_text(PUNCT_CHARS);
		end_source();
		// error held open across a quote literal with an escaped quote
		push_byte(8'h01);
		push_text("'\\''");
		end_source();
		// integer, identifier, blank run, newline, comment, bracket literal, comment at end
		push_text("7a");
		push_byte(CH_TAB);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_text("#z\n[\\]]#");
		end_source();
		// literal left open at the end of the source
		push_byte(CH_QUOTE);
		end_source();

		while (pushed_bytes < SOURCE_ITEMS + 33)
			push_source();

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);

		if (fault_count == 0 && expected_tokens.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/gts_pkg.sv
rtl/gts_scan_core.sv
rtl/gts_out_fifo.sv
rtl/grammar_token_scanner.sv
rtl/gts_checker.sv
verif/grammar_token_scanner_tb.sv
